>>> hdl/trc_pkg.sv
package trc_pkg;

	localparam int ASIN_TABLE_DEPTH = 256;
	localparam int TAB_W            = 22;
	localparam int MAG_W            = 16;
	localparam int OUT_W            = 24;
	localparam int ACC_W            = 52;

	localparam logic [1:0] SEL_ONE   = 2'd0;
	localparam logic [1:0] SEL_TWO   = 2'd1;
	localparam logic [1:0] SEL_THREE = 2'd2;

	typedef struct packed {
		logic [7:0] char_1;
		logic [7:0] char_2;
		logic [7:0] char_3;
		logic [7:0] char_4;
		logic [7:0] char_5;
		logic [7:0] char_6;
		logic [7:0] char_7;
		logic [7:0] char_8;
		logic [1:0] sensor_sel;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] calibrated_value;
		logic                    char_error;
	} out_item_t;

	// control that travels with an item down the pipe
	typedef struct packed {
		logic       valid;
		logic       neg;
		logic       err;
		logic [1:0] sel;
	} ctrl_t;

	// restoring long division, only used while building constants
	function automatic longint unsigned udiv(input longint unsigned num,
			input longint unsigned dvs);
		longint unsigned q;
		logic [64:0]     r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], num[i]};
			if (r >= {1'b0, dvs}) begin
				r    = r - {1'b0, dvs};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// arcsine table entry k, unsigned Q16 degrees, built at elaboration
	function automatic logic [TAB_W-1:0] asin_entry(input int k, input int Depth);
		longint unsigned den, x, x2, term, sum, rad, n;
		den = longint'(Depth) * 64'd160000;
		x   = udiv((longint'(k) << 46) + (den >> 1), den);
		x2  = (x * x + (64'd1 << 29)) >> 30;
		term = x;
		sum  = x;
		for (n = 0; n < 30; n++) begin
			if (term != 0) begin
				term = (term * x2) >> 30;
				term = udiv(term * (2 * n + 1) * (2 * n + 1), (2 * n + 2) * (2 * n + 3));
				sum  = sum + term;
			end
		end
		rad = (sum * 64'd961263685 + (64'd1 << 37)) >> 38;
		return rad[TAB_W-1:0];
	endfunction

	// quadratic coefficients, Q24
	function automatic logic [16:0] coef_a(input logic [1:0] sel);
		case (sel)
			SEL_ONE: return 17'd124822;
			SEL_TWO: return 17'd123648;
			default: return 17'd119789;
		endcase
	endfunction

	function automatic logic signed [26:0] coef_b(input logic [1:0] sel);
		case (sel)
			SEL_ONE: return 27'sd36126211;
			SEL_TWO: return 27'sd36343309;
			default: return 27'sd35620546;
		endcase
	endfunction

	function automatic logic [28:0] coef_c(input logic [1:0] sel);
		case (sel)
			SEL_ONE: return 29'd463599777;
			SEL_TWO: return 29'd468654248;
			default: return 29'd465763199;
		endcase
	endfunction

endpackage

>>> hdl/tilt_reading_calibrator_core.sv
// tilt reading calibrator: one item in, one result out.
// an item is taken on any cycle with start high; busy is always low, so a
// new item may follow every cycle. done marks the result for one cycle and
// cannot be held off by the receiver. the path is decode, arcsine table
// read, interpolation, square and linear term, quadratic sum, rounding;
// one register stage for each of these six steps sets the latency.
// a character outside '0'..'?' flags char_error and gives a zero value.
module tilt_reading_calibrator_core #(
	parameter int ASIN_TABLE_DEPTH = trc_pkg::ASIN_TABLE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  trc_pkg::in_item_t  item,
	output logic               done,
	output trc_pkg::out_item_t result
);
	import trc_pkg::*;

	// stage 1: character decode and difference
	logic [15:0] r1, r2;
	logic        bad;
	logic [1:0]  sel_sat;
	ctrl_t       ctrl_s1;
	logic [MAG_W-1:0] mag_s1;

	function automatic logic char_ok(input logic [7:0] ch);
		return ch[7:4] == 4'h3;
	endfunction

	assign busy = 1'b0;

	// nibble order 7..4, 3..0, 15..12, 11..8
	assign r1 = {item.char_3[3:0], item.char_4[3:0], item.char_1[3:0], item.char_2[3:0]};
	assign r2 = {item.char_7[3:0], item.char_8[3:0], item.char_5[3:0], item.char_6[3:0]};
	assign bad = !(char_ok(item.char_1) && char_ok(item.char_2) && char_ok(item.char_3)
		&& char_ok(item.char_4) && char_ok(item.char_5) && char_ok(item.char_6)
		&& char_ok(item.char_7) && char_ok(item.char_8));
	// select three saturates to the third sensor
	assign sel_sat = (item.sensor_sel == 2'd3) ? SEL_THREE : item.sensor_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid <= start;
			ctrl_s1.neg   <= r2 < r1;
			ctrl_s1.err   <= bad;
			ctrl_s1.sel   <= sel_sat;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1 <= (r2 >= r1) ? (r2 - r1) : (r1 - r2);
	end

	// stages 2 and 3: table read and interpolation
	ctrl_t            ctrl_s3;
	logic [TAB_W-1:0] deg_s3;

	trc_asin #(
		.DEPTH(ASIN_TABLE_DEPTH)
	) u_asin (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl_in (ctrl_s1),
		.mag     (mag_s1),
		.ctrl_out(ctrl_s3),
		.deg     (deg_s3)
	);

	// stage 4: t squared and linear term
	logic signed [TAB_W:0]    t;
	logic signed [TAB_W+27:0] bt;
	ctrl_t                    ctrl_s4;
	logic [2*TAB_W-1:0]       tt_s4;
	logic signed [ACC_W-1:0]  bt_s4;

	assign t  = ctrl_s3.neg ? -$signed({1'b0, deg_s3}) : $signed({1'b0, deg_s3});
	// full-width signed product of b and t
	assign bt = coef_b(ctrl_s3.sel) * t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s4 <= '0;
		end else begin
			ctrl_s4 <= ctrl_s3;
		end
	end

	always_ff @(posedge clk) begin
		tt_s4 <= deg_s3 * deg_s3;
		bt_s4 <= ACC_W'(bt);
	end

	// stage 5: quadratic sum in Q40
	logic [2*TAB_W+16:0]     att;
	ctrl_t                   ctrl_s5;
	logic signed [ACC_W-1:0] acc_s5;

	assign att = coef_a(ctrl_s4.sel) * tt_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s5 <= '0;
		end else begin
			ctrl_s5 <= ctrl_s4;
		end
	end

	always_ff @(posedge clk) begin
		acc_s5 <= $signed(ACC_W'(att[2*TAB_W+16:16])) + bt_s4
			+ $signed(ACC_W'({coef_c(ctrl_s4.sel), 16'd0}));
	end

	// stage 6: round half up to Q16, saturate, zero on bad character
	logic signed [ACC_W-1:0]    biased;
	logic signed [ACC_W-25:0]   rnd;
	logic signed [OUT_W-1:0]    sat;
	localparam logic signed [ACC_W-25:0] MAX_V = (ACC_W-24)'(8388607);
	localparam logic signed [ACC_W-25:0] MIN_V = -(ACC_W-24)'(8388608);

	assign biased = acc_s5 + ACC_W'(64'd1 << 23);
	assign rnd    = biased[ACC_W-1:24];
	assign sat    = (rnd > MAX_V) ? OUT_W'(MAX_V)
		: (rnd < MIN_V) ? OUT_W'(MIN_V) : rnd[OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctrl_s5.valid;
		end
	end

	always_ff @(posedge clk) begin
		result.calibrated_value <= ctrl_s5.err ? '0 : sat;
		result.char_error       <= ctrl_s5.err;
	end

endmodule

>>> hdl/trc_asin.sv
module trc_asin #(
	parameter int DEPTH = trc_pkg::ASIN_TABLE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  trc_pkg::ctrl_t              ctrl_in,
	input  logic [trc_pkg::MAG_W-1:0]   mag,
	output trc_pkg::ctrl_t              ctrl_out,
	output logic [trc_pkg::TAB_W-1:0]   deg
);
	import trc_pkg::*;

	localparam int AW = $clog2(DEPTH + 1);
	localparam int SW = MAG_W + AW;

	typedef logic [TAB_W-1:0] tab_t [DEPTH+1];

	function automatic tab_t build_tab();
		tab_t t;
		for (int k = 0; k <= DEPTH; k++) t[k] = asin_entry(k, DEPTH);
		return t;
	endfunction

	localparam tab_t ASIN_TAB = build_tab();

	logic [SW-1:0]    scaled;
	logic [AW-1:0]    idx;
	logic [AW-1:0]    idx_hi;
	logic [15:0]      frac;

	ctrl_t            ctrl_s2;
	logic [TAB_W-1:0] lo_s2, hi_s2;
	logic [15:0]      frac_s2;
	logic [TAB_W+15:0] prod;

	// mag < 2^16 keeps the index below the depth
	assign scaled = SW'(mag) * SW'(DEPTH);
	assign idx    = scaled[SW-1:MAG_W];
	assign frac   = scaled[15:0];
	assign idx_hi = idx + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2 <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		lo_s2   <= ASIN_TAB[idx];
		hi_s2   <= ASIN_TAB[idx_hi];
		frac_s2 <= frac;
	end

	assign prod = (hi_s2 - lo_s2) * frac_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_out <= '0;
		end else begin
			ctrl_out <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		deg <= lo_s2 + prod[TAB_W+15:16];
	end

endmodule
